[hw/rtl/face_lightmap_extents_unit_defines.svh]
// assertion macros for the face lightmap extents unit
`ifndef FACE_LIGHTMAP_EXTENTS_UNIT_DEFINES_SVH
`define FACE_LIGHTMAP_EXTENTS_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, quiet during rst
`define FLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, quiet during rst
`define FLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/fle_pkg.sv]
// shared types and constants of the face lightmap extents unit
package fle_pkg;

  localparam int COORD_W       = 24;
  localparam int AXIS_W        = 16;
  localparam int OFF_W         = 24;
  localparam int OFF_SHIFT     = 12;
  localparam int PROD_W        = COORD_W + AXIS_W;
  localparam int PROJ_W        = 44;
  localparam int FRAC_BITS     = 20;
  localparam int BLK_W         = 20;
  localparam int SIZE_W        = 7;
  localparam int IDX_W         = 4;
  localparam int CFG_W         = 24;
  localparam int IN_DATA_W     = 72;
  localparam int OUT_DATA_W    = 56;
  localparam int QUEUE_DEPTH   = 4;
  localparam int MAX_EXTENT_DEF = 64;
  localparam int STEP_LOG2_DEF = 4;

  localparam logic signed [AXIS_W-1:0] AXIS_ONE = AXIS_W'(4096);

  typedef enum logic [IDX_W-1:0] {
    REG_S_AXIS_X = 4'd0,
    REG_S_AXIS_Y = 4'd1,
    REG_S_AXIS_Z = 4'd2,
    REG_S_OFFSET = 4'd3,
    REG_T_AXIS_X = 4'd4,
    REG_T_AXIS_Y = 4'd5,
    REG_T_AXIS_Z = 4'd6,
    REG_T_OFFSET = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [PROJ_W-1:0] s;
    logic signed [PROJ_W-1:0] t;
    logic                     last;
  } proj_item_t;

  typedef struct packed {
    logic fin_valid;
    logic first_pending;
  } back_status_t;

endpackage

[hw/rtl/fle_front.sv]
// front end: texture axis registers and two-stage projection pipeline
module fle_front (
  input  logic                    clk,
  input  logic                    rst,
  input  fle_pkg::cfg_wr_t        cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [fle_pkg::IN_DATA_W-1:0] in_data,
  input  logic                    in_last,
  output logic                    push_valid,
  output fle_pkg::proj_item_t     push_item,
  input  logic                    push_ready
);
  import fle_pkg::*;

  logic signed [AXIS_W-1:0] s_axis [3];
  logic signed [AXIS_W-1:0] t_axis [3];
  logic signed [OFF_W-1:0]  s_off;
  logic signed [OFF_W-1:0]  t_off;

  logic signed [COORD_W-1:0] coord [3];
  logic signed [PROD_W-1:0]  s_prod [3];
  logic signed [PROD_W-1:0]  t_prod [3];
  logic                      last1;
  logic                      v1;
  logic                      v2;
  logic                      adv1;
  logic                      adv2;
  logic signed [PROJ_W-1:0]  s_sum;
  logic signed [PROJ_W-1:0]  t_sum;
  proj_item_t                item2;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      s_axis[0] <= AXIS_ONE;
      s_axis[1] <= '0;
      s_axis[2] <= '0;
      s_off     <= '0;
      t_axis[0] <= '0;
      t_axis[1] <= AXIS_ONE;
      t_axis[2] <= '0;
      t_off     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_S_AXIS_X: s_axis[0] <= cfg.data[AXIS_W-1:0];
        REG_S_AXIS_Y: s_axis[1] <= cfg.data[AXIS_W-1:0];
        REG_S_AXIS_Z: s_axis[2] <= cfg.data[AXIS_W-1:0];
        REG_S_OFFSET: s_off     <= cfg.data[OFF_W-1:0];
        REG_T_AXIS_X: t_axis[0] <= cfg.data[AXIS_W-1:0];
        REG_T_AXIS_Y: t_axis[1] <= cfg.data[AXIS_W-1:0];
        REG_T_AXIS_Z: t_axis[2] <= cfg.data[AXIS_W-1:0];
        REG_T_OFFSET: t_off     <= cfg.data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  assign coord[0] = in_data[COORD_W-1:0];
  assign coord[1] = in_data[2*COORD_W-1:COORD_W];
  assign coord[2] = in_data[3*COORD_W-1:2*COORD_W];

  assign adv2     = !v2 || push_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
    end
  end

  // stage one: six independent products
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        s_prod[i] <= coord[i] * s_axis[i];
        t_prod[i] <= coord[i] * t_axis[i];
      end
      last1 <= in_last;
    end
  end

  // stage two: sum and offset at Q24.20
  assign s_sum = PROJ_W'(s_prod[0]) + PROJ_W'(s_prod[1]) + PROJ_W'(s_prod[2])
               + (PROJ_W'(s_off) <<< OFF_SHIFT);
  assign t_sum = PROJ_W'(t_prod[0]) + PROJ_W'(t_prod[1]) + PROJ_W'(t_prod[2])
               + (PROJ_W'(t_off) <<< OFF_SHIFT);

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      item2.s    <= s_sum;
      item2.t    <= t_sum;
      item2.last <= last1;
    end
  end

  assign push_valid = v2;
  assign push_item  = item2;

endmodule

[hw/rtl/fle_queue.sv]
// short queue of projected vertices between front and back
module fle_queue #(
  parameter int DEPTH = fle_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  fle_pkg::proj_item_t push_item,
  output logic                push_ready,
  output logic                pop_valid,
  output fle_pkg::proj_item_t pop_item,
  input  logic                pop
);
  import fle_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  proj_item_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

[hw/rtl/fle_back.sv]
// back end: running min and max per axis, block extents and result register
module fle_back #(
  parameter int MAX_EXTENT = fle_pkg::MAX_EXTENT_DEF,
  parameter int STEP_LOG2  = fle_pkg::STEP_LOG2_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  fle_pkg::proj_item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [fle_pkg::OUT_DATA_W-1:0] out_data,
  output logic                out_ok,
  output fle_pkg::back_status_t status
);
  import fle_pkg::*;

  localparam int SHIFT = FRAC_BITS + STEP_LOG2;

  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [SIZE_W-1:0] size;
    logic              ok;
  } axis_res_t;

  logic signed [PROJ_W-1:0] min_s, max_s, min_t, max_t;
  logic signed [PROJ_W-1:0] min_s_next, max_s_next, min_t_next, max_t_next;
  logic signed [PROJ_W-1:0] fin_min_s, fin_max_s, fin_min_t, fin_max_t;
  logic                     first_pending;
  logic                     fin_valid;
  logic                     out_free;
  logic                     fin_free;
  logic                     fin_take;
  axis_res_t                res_s;
  axis_res_t                res_t;

  function automatic axis_res_t axis_extent(input logic signed [PROJ_W-1:0] lo,
                                            input logic signed [PROJ_W-1:0] hi);
    logic signed [PROJ_W-1:0] fl;
    logic signed [PROJ_W-1:0] cl;
    logic signed [PROJ_W-1:0] ext;
    logic signed [PROJ_W-1:0] sz;
    axis_res_t r;
    fl  = lo >>> SHIFT;
    cl  = (hi >>> SHIFT) + $signed(PROJ_W'(|hi[SHIFT-1:0]));
    ext = cl - fl;
    r.ok = !(ext > $signed(PROJ_W'(MAX_EXTENT)));
    sz  = (r.ok ? ext : $signed(PROJ_W'(MAX_EXTENT))) + PROJ_W'(1);
    r.blk  = fl[BLK_W-1:0];
    r.size = sz[SIZE_W-1:0];
    return r;
  endfunction

  assign out_free = !out_valid || out_ready;
  assign fin_free = !fin_valid || out_free;
  assign fin_take = fin_valid && out_free;
  assign q_pop    = q_valid && (!q_item.last || fin_free);

  always_comb begin
    if (first_pending) begin
      min_s_next = q_item.s;
      max_s_next = q_item.s;
      min_t_next = q_item.t;
      max_t_next = q_item.t;
    end else begin
      min_s_next = (q_item.s < min_s) ? q_item.s : min_s;
      max_s_next = (q_item.s > max_s) ? q_item.s : max_s;
      min_t_next = (q_item.t < min_t) ? q_item.t : min_t;
      max_t_next = (q_item.t > max_t) ? q_item.t : max_t;
    end
  end

  // running extremes and finished polygon holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      fin_valid     <= 1'b0;
      min_s         <= '0;
      max_s         <= '0;
      min_t         <= '0;
      max_t         <= '0;
    end else begin
      if (q_pop) begin
        min_s         <= min_s_next;
        max_s         <= max_s_next;
        min_t         <= min_t_next;
        max_t         <= max_t_next;
        first_pending <= q_item.last;
      end
      fin_valid <= (fin_valid && !fin_take) || (q_pop && q_item.last);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      fin_min_s <= min_s_next;
      fin_max_s <= max_s_next;
      fin_min_t <= min_t_next;
      fin_max_t <= max_t_next;
    end
  end

  assign res_s = axis_extent(fin_min_s, fin_max_s);
  assign res_t = axis_extent(fin_min_t, fin_max_t);

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      out_data <= OUT_DATA_W'({res_t.size, res_s.size, res_t.blk, res_s.blk});
      out_ok   <= res_s.ok && res_t.ok;
    end
  end

  assign status.fin_valid     = fin_valid;
  assign status.first_pending = first_pending;

endmodule

[hw/rtl/face_lightmap_extents_unit.sv]
// Lightmap extents of a polygon from a stream of vertices.
// s_axis carries one vertex per word, tlast on the polygon's final vertex.
// Each vertex is projected onto the S and T texture axes at Q24.20; the
// running min and max per axis give, on the final vertex, one m_axis word
// with the floored minimum blocks and the clamped sizes, tuser the ok flag.
// cfg writes the eight axis and offset registers by index, one per cycle;
// the user writes only while no polygon is in flight (the block does not
// enforce it); indexes past the list are ignored. Throughput: one vertex
// per cycle while s_axis_tready is high, set by the six projection
// multipliers and the single min/max compare stage. A final vertex passes
// through the product and sum registers, queue, min/max, extent and output.
// Reset clears the pipeline, queue and result register and loads the
// default axes (S along x, T along y, zero offsets).
// When m_axis stalls, the result waits in the output register, one more
// finished polygon waits behind it, and the queue fills; s_axis_tready
// drops only once all of these are full.
`include "face_lightmap_extents_unit_defines.svh"

module face_lightmap_extents_unit #(
  parameter int MAX_EXTENT  = fle_pkg::MAX_EXTENT_DEF,
  parameter int STEP_LOG2   = fle_pkg::STEP_LOG2_DEF,
  parameter int QUEUE_DEPTH = fle_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fle_pkg::IDX_W-1:0]          cfg_index,
  input  logic [fle_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // vertex_x, vertex_y, vertex_z
  input  logic [fle_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // min_s_block, min_t_block, width_blocks, height_blocks, zero pad
  output logic [fle_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // extents_ok
  output logic                               m_axis_tuser
);
  import fle_pkg::*;

  cfg_wr_t      cfg;
  logic         push_valid;
  logic         push_ready;
  proj_item_t   push_item;
  logic         q_valid;
  proj_item_t   q_item;
  logic         q_pop;
  back_status_t status;

  assign cfg_ready  = 1'b1;
  assign cfg.valid  = cfg_valid;
  assign cfg.index  = cfg_index;
  assign cfg.data   = cfg_data;

  fle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  fle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  fle_back #(
    .MAX_EXTENT (MAX_EXTENT),
    .STEP_LOG2  (STEP_LOG2)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_ok    (m_axis_tuser),
    .status    (status)
  );

  `FLE_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")
  `FLE_ASSERT_NOW(a_result_from_fin, $rose(m_axis_tvalid), $past(status.fin_valid), "result word without finished polygon")
  `FLE_ASSERT_NEXT(a_last_closes, q_pop && q_item.last, status.fin_valid && status.first_pending, "final vertex did not close polygon")
  `FLE_ASSERT_NOW(a_reset_quiet, $past(rst), !m_axis_tvalid, "result word right after reset")

endmodule
